/* sv/fraction_arith_reduce_defines.svh */
// Assertion macros for the fraction arithmetic block.
// Used by the top level; no other dependencies.
`ifndef FRACTION_ARITH_REDUCE_DEFINES_SVH
`define FRACTION_ARITH_REDUCE_DEFINES_SVH
`ifndef SYNTHESIS
// Property holds at every edge outside reset
`define FRA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Antecedent this cycle implies consequent the next cycle
`define FRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define FRA_ASSERT(lbl, clk, rstn, prop, msg)
`define FRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* sv/fra_pkg.sv */
// Shared types and constants of the fraction arithmetic block.
// No dependencies.
`default_nettype none
package fra_pkg;
  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int NUM_WIDTH = 33;
  localparam int DEN_WIDTH = 31;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic form;
    logic gcd_step;
    logic shl_step;
    logic div_load_num;
    logic div_load_den;
    logic div_step;
    logic latch_num;
    logic latch_den;
    logic fin;
  } fra_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic err;
    logic ga_zero;
    logic k_zero;
    logic cnt_zero;
  } fra_stat_t;
endpackage
`default_nettype wire

/* sv/fraction_arith_reduce.sv */
// Top level of the fraction arithmetic block: controller plus datapath.
// Depends on fra_pkg, fra_ctrl, fra_dp and the assertion macro header.
//
// Takes two fractions and a command (add, subtract, multiply, divide) when
// start_i is high and busy_o low, and returns the reduced fraction with a
// positive denominator. The result word is on the result ports when done_o is
// high for one cycle; the receiver cannot stall, so capture it then.
// A zero denominator or division by a zero fraction gives 0/1, status 1.
// A word passes through operand load, multiply, forming the magnitudes,
// the binary GCD steps, the restored power-of-two shifts and two bit-serial
// divisions of P = 2*OPERAND_WIDTH+1 bits (numerator, then denominator)
// before the result registers are loaded. Error words go from the multiply
// straight to the result. busy_o falls in the cycle after done_o, and the
// next word is taken only once busy_o is low.
`default_nettype none
`include "fraction_arith_reduce_defines.svh"
module fraction_arith_reduce import fra_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [1:0]                   command_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_num_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_den_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_num_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_den_i,
  output logic                              done_o,
  output logic signed [NUM_WIDTH-1:0]       result_num_o,
  output logic [DEN_WIDTH-1:0]              result_den_o,
  output logic                              status_o
);
  fra_cmd_t  cmd;
  fra_stat_t stat;

  fra_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  fra_dp #(.OperandWidth(OPERAND_WIDTH)) u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .command_i   (command_i),
    .a_num_i     (a_num_i),
    .a_den_i     (a_den_i),
    .b_num_i     (b_num_i),
    .b_den_i     (b_den_i),
    .result_num_o(result_num_o),
    .result_den_o(result_den_o),
    .status_o    (status_o)
  );

  // checks
  `FRA_ASSERT(a_err_word, clk_i, rst_ni, !(done_o && status_o) || (result_num_o == '0 && result_den_o == DEN_WIDTH'(1)), "error word not 0/1")
  `FRA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o, "accepted word did not raise busy")
  `FRA_ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, done_o, !done_o, "result strobe longer than one cycle")
  `FRA_ASSERT(a_strobe_busy, clk_i, rst_ni, !done_o || busy_o, "result strobe while idle")
endmodule
`default_nettype wire

/* sv/fra_dp.sv */
// Datapath: multipliers, binary GCD unit, shared restoring divider, result registers.
// Depends on fra_pkg.
`default_nettype none
module fra_dp import fra_pkg::*; #(
  parameter int OperandWidth = OPERAND_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire fra_cmd_t                    cmd_i,
  output fra_stat_t                        stat_o,
  input  wire logic [1:0]                  command_i,
  input  wire logic signed [OperandWidth-1:0] a_num_i,
  input  wire logic signed [OperandWidth-1:0] a_den_i,
  input  wire logic signed [OperandWidth-1:0] b_num_i,
  input  wire logic signed [OperandWidth-1:0] b_den_i,
  output logic signed [NUM_WIDTH-1:0]      result_num_o,
  output logic [DEN_WIDTH-1:0]             result_den_o,
  output logic                             status_o
);
  localparam int W2 = 2 * OperandWidth;
  localparam int PW = W2 + 1;
  localparam int KW = $clog2(PW + 1);
  localparam int RW = (PW > NUM_WIDTH) ? PW : NUM_WIDTH;

  logic [1:0] op_q;
  logic signed [OperandWidth-1:0] an_q, ad_q, bn_q, bd_q;
  logic err_q;
  logic signed [W2-1:0] p1_q, p2_q, p3_q;
  logic [PW-1:0] nm_q, dm_q, ga_q, gb_q, rem_q, quo_q, nq_q, dq_q;
  logic neg_q;
  logic [KW-1:0] k_q, cnt_q;
  logic signed [NUM_WIDTH-1:0] rnum_q;
  logic [DEN_WIDTH-1:0] rden_q;
  logic rstat_q;

  // raw numerator and denominator
  logic signed [PW-1:0] num_w, den_w;
  logic [PW-1:0] num_mag, den_mag;
  always_comb begin
    case (op_q)
      CMD_ADD: num_w = PW'(p1_q) + PW'(p2_q);
      CMD_SUB: num_w = PW'(p1_q) - PW'(p2_q);
      default: num_w = PW'(p1_q);
    endcase
    den_w = PW'(p3_q);
    num_mag = num_w[PW-1] ? PW'(-num_w) : PW'(num_w);
    den_mag = den_w[PW-1] ? PW'(-den_w) : PW'(den_w);
  end

  // divider trial subtract
  logic [PW:0] rem_sh, trial;
  always_comb begin
    rem_sh = {rem_q, quo_q[PW-1]};
    trial  = rem_sh - {1'b0, gb_q};
  end

  // result formatting
  logic [RW-1:0] nq_ext, nq_neg, dq_ext;
  always_comb begin
    nq_ext = RW'(nq_q);
    nq_neg = (neg_q && nq_q != '0) ? (~nq_ext + RW'(1)) : nq_ext;
    dq_ext = RW'(dq_q);
  end

  always_ff @(posedge clk_i) begin
    // capture operands and input checks
    if (cmd_i.load) begin
      op_q <= command_i;
      an_q <= a_num_i;
      ad_q <= a_den_i;
      bn_q <= b_num_i;
      bd_q <= b_den_i;
      err_q <= (a_den_i == '0) || (b_den_i == '0) ||
               ((command_i == CMD_DIV) && (b_num_i == '0));
    end
    // cross products
    if (cmd_i.mul) begin
      p1_q <= an_q * ((op_q == CMD_MUL) ? bn_q : bd_q);
      p2_q <= ad_q * bn_q;
      p3_q <= ad_q * ((op_q == CMD_DIV) ? bn_q : bd_q);
    end
    // magnitudes and sign
    if (cmd_i.form) begin
      nm_q  <= num_mag;
      dm_q  <= den_mag;
      ga_q  <= num_mag;
      gb_q  <= den_mag;
      neg_q <= num_w[PW-1] ^ den_w[PW-1];
      k_q   <= '0;
    end
    // binary GCD step
    if (cmd_i.gcd_step) begin
      if (!ga_q[0] && !gb_q[0]) begin
        ga_q <= ga_q >> 1;
        gb_q <= gb_q >> 1;
        k_q  <= k_q + KW'(1);
      end else if (!ga_q[0]) begin
        ga_q <= ga_q >> 1;
      end else if (!gb_q[0]) begin
        gb_q <= gb_q >> 1;
      end else if (ga_q >= gb_q) begin
        ga_q <= ga_q - gb_q;
      end else begin
        gb_q <= gb_q - ga_q;
      end
    end
    // restore common power of two
    if (cmd_i.shl_step) begin
      gb_q <= gb_q << 1;
      k_q  <= k_q - KW'(1);
    end
    // divider
    if (cmd_i.div_load_num || cmd_i.div_load_den) begin
      quo_q <= cmd_i.div_load_num ? nm_q : dm_q;
      rem_q <= '0;
      cnt_q <= KW'(PW);
    end
    if (cmd_i.div_step) begin
      if (!trial[PW]) begin
        rem_q <= trial[PW-1:0];
        quo_q <= {quo_q[PW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[PW-1:0];
        quo_q <= {quo_q[PW-2:0], 1'b0};
      end
      cnt_q <= cnt_q - KW'(1);
    end
    if (cmd_i.latch_num) nq_q <= quo_q;
    if (cmd_i.latch_den) dq_q <= quo_q;
    // result word
    if (cmd_i.fin) begin
      if (err_q) begin
        rnum_q  <= '0;
        rden_q  <= DEN_WIDTH'(1);
        rstat_q <= 1'b1;
      end else begin
        rnum_q  <= nq_neg[NUM_WIDTH-1:0];
        rden_q  <= dq_ext[DEN_WIDTH-1:0];
        rstat_q <= 1'b0;
      end
    end
  end

  assign stat_o.err      = err_q;
  assign stat_o.ga_zero  = (ga_q == '0);
  assign stat_o.k_zero   = (k_q == '0);
  assign stat_o.cnt_zero = (cnt_q == '0);

  assign result_num_o = rnum_q;
  assign result_den_o = rden_q;
  assign status_o     = rstat_q;
endmodule
`default_nettype wire

/* sv/fra_ctrl.sv */
// Controller: sequences load, multiply, GCD, two divisions and result strobe.
// Depends on fra_pkg.
`default_nettype none
module fra_ctrl import fra_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire fra_stat_t stat_i,
  output fra_cmd_t       cmd_o,
  output logic           busy_o,
  output logic           done_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_FORM, S_GCD, S_SHL, S_DNI, S_DN, S_DDI, S_DD, S_FIN, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic done_q, done_d;

  // commands and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = stat_i.err ? S_FIN : S_FORM;
      end
      S_FORM: begin
        cmd_o.form = 1'b1;
        state_d = S_GCD;
      end
      S_GCD: begin
        if (stat_i.ga_zero) state_d = S_SHL;
        else cmd_o.gcd_step = 1'b1;
      end
      S_SHL: begin
        if (stat_i.k_zero) state_d = S_DNI;
        else cmd_o.shl_step = 1'b1;
      end
      S_DNI: begin
        cmd_o.div_load_num = 1'b1;
        state_d = S_DN;
      end
      S_DN: begin
        if (stat_i.cnt_zero) begin
          cmd_o.latch_num = 1'b1;
          state_d = S_DDI;
        end else cmd_o.div_step = 1'b1;
      end
      S_DDI: begin
        cmd_o.div_load_den = 1'b1;
        state_d = S_DD;
      end
      S_DD: begin
        if (stat_i.cnt_zero) begin
          cmd_o.latch_den = 1'b1;
          state_d = S_FIN;
        end else cmd_o.div_step = 1'b1;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        done_d  = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // state and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
endmodule
`default_nettype wire

/* tb/fraction_arith_reduce_tb.sv */
// Testbench for fraction_arith_reduce: drives commands, with random gaps in
// most phases, and checks every result word against a behavioral predictor.
// Depends on fra_pkg and the fraction_arith_reduce RTL.
`timescale 1ns / 100ps
module fraction_arith_reduce_tb;
  import fra_pkg::*;

  localparam int OW = OPERAND_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [NUM_WIDTH-1:0] num;
    logic [DEN_WIDTH-1:0]        den;
    logic                        status;
  } frac_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [1:0] command_i = CMD_ADD;
  logic signed [OW-1:0] a_num_i = '0, a_den_i = '0, b_num_i = '0, b_den_i = '0;
  logic busy_o, done_o, status_o;
  logic signed [NUM_WIDTH-1:0] result_num_o;
  logic [DEN_WIDTH-1:0] result_den_o;

  frac_word_t reduced_q[$];
  int mismatches = 0;
  int cycles = 0;
  bit idle_on = 1'b1;

  fraction_arith_reduce u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .command_i,
    .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .done_o, .result_num_o, .result_den_o, .status_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Exact 64-bit rational op, gcd reduction, sign moved to numerator
  function automatic frac_word_t reduce_frac(logic [1:0] op, logic signed [OW-1:0] an,
                                             logic signed [OW-1:0] ad,
                                             logic signed [OW-1:0] bn,
                                             logic signed [OW-1:0] bd);
    longint n, d, x, y, t;
    longint unsigned nm, dm;
    frac_word_t w;
    w = '{num: '0, den: 1, status: 1'b1};
    if (ad == 0 || bd == 0 || (op == CMD_DIV && bn == 0)) return w;
    case (op)
      CMD_ADD: begin n = an * bd + ad * bn; d = longint'(ad) * bd; end
      CMD_SUB: begin n = an * bd - ad * bn; d = longint'(ad) * bd; end
      CMD_MUL: begin n = longint'(an) * bn; d = longint'(ad) * bd; end
      default: begin n = longint'(an) * bd; d = longint'(ad) * bn; end
    endcase
    x = (n < 0) ? -n : n;
    y = (d < 0) ? -d : d;
    nm = x;
    dm = y;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    nm = nm / x;
    dm = dm / x;
    w.status = 1'b0;
    w.den = dm[DEN_WIDTH-1:0];
    w.num = NUM_WIDTH'((nm != 0 && ((n < 0) != (d < 0))) ? -longint'(nm) : longint'(nm));
    return w;
  endfunction

  task automatic idle_burst();
    if (idle_on && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
  endtask

  // Send one word: hold start until accepted with busy low
  task automatic send_word(logic [1:0] op, logic signed [OW-1:0] an,
                           logic signed [OW-1:0] ad, logic signed [OW-1:0] bn,
                           logic signed [OW-1:0] bd);
    // step past the edge that dropped start for the previous word
    @(posedge clk_i);
    idle_burst();
    start_i <= 1'b1;
    command_i <= op;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    do @(posedge clk_i); while (busy_o);
    reduced_q.push_back(reduce_frac(op, an, ad, bn, bd));
    start_i <= 1'b0;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    frac_word_t e;
    cycles <= cycles + 1;
    if (rst_ni && done_o) begin
      if (reduced_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %0d/%0d st %0d",
                                       result_num_o, result_den_o, status_o);
      end else begin
        e = reduced_q.pop_front();
        if (e.num !== result_num_o || e.den !== result_den_o || e.status !== status_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d st %0d, got %0d/%0d st %0d",
                     e.num, e.den, e.status, result_num_o, result_den_o, status_o);
        end
      end
    end
  end

  task automatic test_directed();
    logic signed [OW-1:0] mx, mn;
    mx = {1'b0, {(OW-1){1'b1}}};
    mn = {1'b1, {(OW-1){1'b0}}};
    for (int op = 0; op < 4; op++) begin
      send_word(2'(op), mx, mx, mx, mx);
      send_word(2'(op), mn, mn, mn, mn);
      send_word(2'(op), mn, 1, mn, -1);
      send_word(2'(op), mx, mn, -1, mx);
    end
    send_word(CMD_ADD, 3, 0, 1, 2);     // zero denominator
    send_word(CMD_MUL, 3, 4, 1, 0);
    send_word(CMD_DIV, 3, 4, 0, 5);     // divide by zero fraction
    send_word(CMD_SUB, 2, 3, 2, 3);     // zero numerator
    send_word(CMD_MUL, 0, -7, 5, 3);
    send_word(CMD_ADD, 1, 2, 1, 2);
    send_word(CMD_DIV, -6, 4, 9, -2);
  endtask

  function automatic logic signed [OW-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return OW'($urandom_range(0, 7) - 3);
      1: return OW'($urandom_range(0, 200) - 100);
      default: return OW'($urandom);
    endcase
  endfunction

  task automatic test_random(int n);
    logic signed [OW-1:0] ad, bd;
    for (int i = 0; i < n; i++) begin
      ad = rand_operand();
      bd = rand_operand();
      send_word(2'($urandom_range(0, 3)), rand_operand(), ad, rand_operand(), bd);
    end
  endtask

  // Sender holds off until every outstanding word is back
  task automatic test_drain_pause();
    while (reduced_q.size() != 0) @(posedge clk_i);
    test_random(50);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1100);
    test_drain_pause();
    idle_on = 1'b0;
    test_random(380);
    while (reduced_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) $display("fraction_arith_reduce regression: pass");
    else $display("fraction_arith_reduce regression: fail");
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("fraction_arith_reduce regression: fail");
    $finish;
  end
endmodule

/* sim.f */
+incdir+sv
sv/fra_pkg.sv
sv/fra_dp.sv
sv/fra_ctrl.sv
sv/fraction_arith_reduce.sv
tb/fraction_arith_reduce_tb.sv
